>>> rtl/core/amr_rtp_payload_depacketizer_assert.svh
// Assertion shorthands; clk and rst_n must be in scope where used.
`ifndef AMR_RTP_PAYLOAD_DEPACKETIZER_ASSERT_SVH
`define AMR_RTP_PAYLOAD_DEPACKETIZER_ASSERT_SVH

// same-cycle implication
`define AMR_AST_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AMR_AST_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/amr_pkg.sv
`timescale 1ns / 1ps

package amr_pkg;

    localparam int TOC_DEPTH_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTET_ALIGNED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDEBAND      = 2'd1;

    localparam logic [3:0] MODE_RESET = 4'd7;
    localparam logic [3:0] CMR_KEEP   = 4'd15;
    localparam logic [3:0] FT_WB_BAD  = 4'd10;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FT    = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    localparam logic [5:0] NB_LEN [16] = '{
        6'd12, 6'd13, 6'd15, 6'd17, 6'd19, 6'd20, 6'd26, 6'd31,
        6'd5,  6'd6,  6'd5,  6'd5,  6'd0,  6'd0,  6'd0,  6'd0
    };
    localparam logic [5:0] WB_LEN [16] = '{
        6'd17, 6'd23, 6'd32, 6'd36, 6'd40, 6'd46, 6'd50, 6'd58,
        6'd60, 6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
    };

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TOC,
        PH_DATA,
        PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNIT,
        S_FETCH,
        S_START,
        S_FLUSH,
        S_STATUS,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic do_unit;
        logic do_start;
        logic do_flush;
        logic do_status;
        logic rel_hold;
    } dp_cmd_t;

    typedef struct packed {
        logic drain;
        logic short_unit;
        logic unit_emits;
        logic unit_fetch;
        logic frame_more;
        logic start_bad;
        logic start_empty;
        logic flush_go;
        logic flush_fetch;
        logic can_emit;
        logic out_free;
        logic hold_valid;
        logic last;
    } dp_sts_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_toc;
        logic [3:0] frame_number;
        logic       frame_end;
        logic       packet_status;
        logic [1:0] status_code;
        logic [4:0] frames_seen;
        logic [3:0] mode_request;
    } res_t;

    function automatic logic [5:0] frame_len(input logic [3:0] ft, input logic wb);
        frame_len = wb ? WB_LEN[ft] : NB_LEN[ft];
    endfunction

endpackage

>>> rtl/core/amr_in_if.sv
`timescale 1ns / 1ps

interface amr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

>>> rtl/core/amr_out_if.sv
`timescale 1ns / 1ps

interface amr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_toc;
    logic [3:0] frame_number;
    logic       frame_end;
    logic       packet_status;
    logic [1:0] status_code;
    logic [4:0] frames_seen;
    logic [3:0] mode_request;
    logic       run_last;

    modport source (output valid, output frame_byte, output is_toc, output frame_number,
                    output frame_end, output packet_status, output status_code,
                    output frames_seen, output mode_request, output run_last, input ready);
    modport sink   (input valid, input frame_byte, input is_toc, input frame_number,
                    input frame_end, input packet_status, input status_code,
                    input frames_seen, input mode_request, input run_last, output ready);
endinterface

>>> rtl/core/amr_cfg_if.sv
`timescale 1ns / 1ps

interface amr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/amr_ram.sv
`timescale 1ns / 1ps

module amr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/amr_ctrl.sv
`timescale 1ns / 1ps

module amr_ctrl
    import amr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);
    ctrl_state_t state_reg, state_next;
    logic        flush_reg, flush_next;
    ctrl_state_t ret_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign ret_state = flush_reg ? S_STATUS : S_UNIT;

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    flush_next = 1'b0;
                    state_next = S_UNIT;
                end
            end
            S_UNIT:
            begin
                if (sts.drain)
                begin
                    cmd.do_unit = 1'b1;
                    state_next  = sts.last ? S_FLUSH : S_DONE;
                end
                else if (sts.short_unit)
                begin
                    state_next = sts.last ? S_FLUSH : S_DONE;
                end
                else if (!sts.unit_emits || sts.can_emit)
                begin
                    cmd.do_unit = 1'b1;
                    if (sts.unit_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = sts.frame_more ? S_START : ret_state;
            end
            S_START:
            begin
                if (sts.start_bad)
                begin
                    cmd.do_start = 1'b1;
                    state_next   = ret_state;
                end
                else if (sts.can_emit)
                begin
                    cmd.do_start = 1'b1;
                    state_next   = sts.start_empty ? S_FETCH : ret_state;
                end
            end
            S_FLUSH:
            begin
                if (!sts.flush_go)
                begin
                    state_next = S_STATUS;
                end
                else if (sts.can_emit)
                begin
                    cmd.do_flush = 1'b1;
                    flush_next   = 1'b1;
                    state_next   = sts.flush_fetch ? S_FETCH : S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (sts.can_emit)
                begin
                    cmd.do_status = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.rel_hold = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/core/amr_dp.sv
`timescale 1ns / 1ps

`include "amr_rtp_payload_depacketizer_assert.svh"

module amr_dp
    import amr_pkg::*;
#(
    parameter int TOC_DEPTH = TOC_DEPTH_DEF,
    localparam int CNT_W = $clog2(TOC_DEPTH + 1),
    localparam int IDX_W = (TOC_DEPTH > 1) ? $clog2(TOC_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [4:0]            ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [4:0]            ram_rdata,
    output res_t                  out_res,
    output logic                  out_run_last,
    output logic                  out_valid,
    input  logic                  out_ready
);
    logic             oa_reg, wb_reg;
    phase_t           phase_reg;
    logic [CNT_W-1:0] tc_reg, fc_reg;
    logic [5:0]       bl_reg;
    logic [14:0]      acc_reg;
    logic [3:0]       avail_reg;
    logic [3:0]       mode_reg;
    logic             last_reg;
    res_t             hold_reg;
    logic             hold_valid_reg;
    res_t             out_reg;
    logic             out_last_reg, out_valid_reg;

    logic [22:0]      shifted;
    logic [7:0]       win;
    logic [3:0]       unit_w;
    logic             in_frame, bad_ft, emit, can_emit, out_free;
    logic [3:0]       ft;
    logic [5:0]       len;
    logic [CNT_W+4:0] fc_ext, seen_sum;
    logic [6:0]       carry_mask;
    logic [7:0]       flush_byte;
    logic [1:0]       code;
    res_t             new_res;

    // next 8 payload bits, MSB first, zero filled past the buffered bits
    assign shifted = {acc_reg, 8'h00} >> avail_reg;
    assign win     = shifted[7:0];

    always_comb
    begin
        case (phase_reg)
            PH_HEADER: unit_w = oa_reg ? 4'd8 : 4'd4;
            PH_TOC:    unit_w = oa_reg ? 4'd8 : 4'd6;
            default:   unit_w = 4'd8;
        endcase
    end

    assign in_frame   = (phase_reg == PH_DATA) && (fc_reg < tc_reg) && (bl_reg != 6'd0);
    assign ft         = ram_rdata[4:1];
    assign len        = frame_len(ft, wb_reg);
    assign bad_ft     = wb_reg && (ft >= FT_WB_BAD);
    assign fc_ext     = {5'b0, fc_reg};
    assign seen_sum   = fc_ext + {{(CNT_W+4){1'b0}}, in_frame};
    assign carry_mask = 7'((8'd1 << avail_reg[2:0]) - 8'd1);
    assign flush_byte = 8'({8'h00, acc_reg[7:0]} << (4'd8 - avail_reg));

    always_comb
    begin
        case (phase_reg)
            PH_DRAIN: code = bl_reg[1:0];
            PH_DATA:  code = (fc_reg < tc_reg) ? ST_TRUNCATED : ST_OK;
            default:  code = ST_TRUNCATED;
        endcase
    end

    always_comb
    begin
        new_res              = '0;
        new_res.mode_request = mode_reg;
        new_res.frame_number = fc_ext[3:0];
        if (cmd.do_status)
        begin
            new_res.frame_number  = 4'd0;
            new_res.packet_status = 1'b1;
            new_res.status_code   = code;
            new_res.frames_seen   = seen_sum[4:0];
        end
        else if (cmd.do_start)
        begin
            new_res.frame_byte = {1'b0, ram_rdata, 2'b00};
            new_res.is_toc     = 1'b1;
            new_res.frame_end  = (len == 6'd0);
        end
        else
        begin
            new_res.frame_byte = cmd.do_flush ? flush_byte : win;
            new_res.frame_end  = (bl_reg == 6'd1);
        end
    end

    assign emit = (cmd.do_unit && phase_reg == PH_DATA && in_frame)
                || (cmd.do_start && !bad_ft) || cmd.do_flush || cmd.do_status;
    assign out_free = !out_valid_reg || out_ready;
    assign can_emit = !hold_valid_reg || out_free;

    assign ram_we    = cmd.do_unit && (phase_reg == PH_TOC) && (tc_reg < CNT_W'(TOC_DEPTH));
    assign ram_waddr = tc_reg[IDX_W-1:0];
    assign ram_wdata = win[6:2];
    assign ram_raddr = fc_reg[IDX_W-1:0];

    always_comb
    begin
        sts             = '0;
        sts.drain       = (phase_reg == PH_DRAIN);
        sts.short_unit  = (avail_reg < unit_w);
        sts.unit_emits  = (phase_reg == PH_DATA) && in_frame;
        sts.unit_fetch  = ((phase_reg == PH_TOC) && !win[7])
                        || ((phase_reg == PH_DATA) && in_frame && (bl_reg == 6'd1));
        sts.frame_more  = (fc_reg < tc_reg);
        sts.start_bad   = bad_ft;
        sts.start_empty = (len == 6'd0);
        sts.flush_go    = (avail_reg != 4'd0) && in_frame;
        sts.flush_fetch = (bl_reg == 6'd1);
        sts.can_emit    = can_emit;
        sts.out_free    = out_free;
        sts.hold_valid  = hold_valid_reg;
        sts.last        = last_reg;
    end

    // config and packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oa_reg    <= 1'b1;
            wb_reg    <= 1'b0;
            phase_reg <= PH_HEADER;
            tc_reg    <= '0;
            fc_reg    <= '0;
            bl_reg    <= '0;
            acc_reg   <= '0;
            avail_reg <= '0;
            mode_reg  <= MODE_RESET;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_OCTET_ALIGNED)
            begin
                oa_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_WIDEBAND)
            begin
                wb_reg <= cfg_data[0];
            end

            if (cmd.accept)
            begin
                acc_reg   <= {acc_reg[6:0] & carry_mask, in_byte};
                avail_reg <= avail_reg + 4'd8;
                last_reg  <= in_last;
            end

            if (cmd.do_unit)
            begin
                if (phase_reg == PH_DRAIN)
                begin
                    avail_reg <= '0;
                end
                else
                begin
                    avail_reg <= avail_reg - unit_w;
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (win[7:4] != CMR_KEEP)
                            begin
                                mode_reg <= win[7:4];
                            end
                            phase_reg <= PH_TOC;
                            tc_reg    <= '0;
                            fc_reg    <= '0;
                            bl_reg    <= '0;
                        end
                        PH_TOC:
                        begin
                            if (tc_reg < CNT_W'(TOC_DEPTH))
                            begin
                                tc_reg <= tc_reg + 1'b1;
                            end
                            if (!win[7])
                            begin
                                phase_reg <= PH_DATA;
                                fc_reg    <= '0;
                                bl_reg    <= '0;
                            end
                            else if (tc_reg + 1'b1 >= CNT_W'(TOC_DEPTH))
                            begin
                                phase_reg <= PH_DRAIN;
                                bl_reg    <= {4'd0, ST_TOO_MANY};
                            end
                        end
                        PH_DATA:
                        begin
                            if (in_frame)
                            begin
                                bl_reg <= bl_reg - 6'd1;
                                if (bl_reg == 6'd1)
                                begin
                                    fc_reg <= fc_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            phase_reg <= PH_DRAIN;
                        end
                    endcase
                end
            end

            if (cmd.do_start)
            begin
                if (bad_ft)
                begin
                    phase_reg <= PH_DRAIN;
                    bl_reg    <= {4'd0, ST_BAD_FT};
                end
                else if (len == 6'd0)
                begin
                    fc_reg <= fc_reg + 1'b1;
                end
                else
                begin
                    bl_reg <= len;
                end
            end

            if (cmd.do_flush)
            begin
                bl_reg    <= bl_reg - 6'd1;
                acc_reg   <= '0;
                avail_reg <= '0;
                if (bl_reg == 6'd1)
                begin
                    fc_reg <= fc_reg + 1'b1;
                end
            end

            if (cmd.do_status)
            begin
                phase_reg <= PH_HEADER;
                tc_reg    <= '0;
                fc_reg    <= '0;
                bl_reg    <= '0;
                acc_reg   <= '0;
                avail_reg <= '0;
            end
        end
    end

    // hold stage: a beat is released once the next one (or end of byte) is known
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((emit && hold_valid_reg) || cmd.rel_hold)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.rel_hold)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((emit && hold_valid_reg) || cmd.rel_hold)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= cmd.rel_hold;
        end
        if (emit)
        begin
            hold_reg <= new_res;
        end
    end

    assign out_res      = out_reg;
    assign out_run_last = out_last_reg;
    assign out_valid    = out_valid_reg;

    `AMR_AST_IMP(a_emit_room, emit, can_emit, "beat produced with no room")
    `AMR_AST_IMP(a_cursor_bound, 1'b1, (fc_reg <= tc_reg) && (tc_reg <= CNT_W'(TOC_DEPTH)), "frame cursor past ToC count")
    `AMR_AST_NXT(a_accept_bits, cmd.accept, avail_reg >= 4'd8, "accepted byte not buffered")
endmodule

>>> rtl/core/amr_rtp_payload_depacketizer.sv
`timescale 1ns / 1ps

// AMR RTP payload depacketizer: payload bytes in (octet-aligned or
// bandwidth-efficient layout), rebuilt octet-aligned frames out as a ToC beat
// followed by the frame's speech beats, then one status beat per packet.
// Per byte, the controller accepts it, takes each field from the bit buffer in
// turn (at most two per byte), finds the buffer short of the next field, then
// closes with a step that releases the byte's last beat. Each frame started
// also passes through a fetch and a start step (ToC store read has a registered
// port), empty frames included. The last byte of a packet adds a flush and a
// status step; once a packet is draining a byte takes only the accept, drain
// and closing steps. The controller extracts a single field at a time, and
// output back-pressure can stall any emitting step. Config writes are
// taken at any time and apply at once; the ToC store needs no clearing.
module amr_rtp_payload_depacketizer
    import amr_pkg::*;
#(
    parameter int TOC_DEPTH = TOC_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    amr_in_if.sink   payload,
    amr_out_if.source frames,
    amr_cfg_if.sink  cfg
);
    localparam int IDX_W = (TOC_DEPTH > 1) ? $clog2(TOC_DEPTH) : 1;

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [4:0]       ram_wdata, ram_rdata;
    res_t             res;
    logic             run_last;

    assign cfg.ready = 1'b1;

    amr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (payload.valid),
        .in_ready (payload.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    amr_dp #(
        .TOC_DEPTH (TOC_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .in_byte      (payload.payload_byte),
        .in_last      (payload.last_byte),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_res      (res),
        .out_run_last (run_last),
        .out_valid    (frames.valid),
        .out_ready    (frames.ready)
    );

    // ToC entries of the current packet (F dropped: FT and Q)
    amr_ram #(
        .WIDTH (5),
        .DEPTH (TOC_DEPTH)
    ) u_toc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign frames.frame_byte    = res.frame_byte;
    assign frames.is_toc        = res.is_toc;
    assign frames.frame_number  = res.frame_number;
    assign frames.frame_end     = res.frame_end;
    assign frames.packet_status = res.packet_status;
    assign frames.status_code   = res.status_code;
    assign frames.frames_seen   = res.frames_seen;
    assign frames.mode_request  = res.mode_request;
    assign frames.run_last      = run_last;
endmodule
